// ----- hw/rtl/dpx_pkg.sv -----
// Shared types and constants for the DVD pack PES payload extractor.
// No dependencies.
`default_nettype none
package dpx_pkg;
    localparam int PACK_BYTES     = 2048;
    localparam int PACK_HDR_BYTES = 14;
    // position width: covers start + 6 + 16-bit length twice over
    localparam int POS_W = 18;
    localparam int PP_W  = $clog2(PACK_BYTES);

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       byte_valid;
        logic [7:0] stream_id;
        logic [7:0] substream_id;
        logic       first_of_packet;
        logic       end_of_packet;
    } t_item;
endpackage
`default_nettype wire

// ----- hw/rtl/dpx_if.sv -----
// Valid/ready channel interfaces for input bytes and result beats.
// No dependencies.
`default_nettype none
interface dpx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface dpx_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic [7:0] stream_id;
    logic [7:0] substream_id;
    logic       first_of_packet;
    logic       end_of_packet;
    modport source (output valid, output payload_byte, output byte_valid, output stream_id,
                    output substream_id, output first_of_packet, output end_of_packet,
                    input ready);
    modport sink   (input valid, input payload_byte, input byte_valid, input stream_id,
                    input substream_id, input first_of_packet, input end_of_packet,
                    output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/dvd_pack_pes_payload_extractor_unit.sv -----
// A byte that yields a result is written into the queue and then into the output register before it shows.
// Throughput: one byte per cycle while the queue has room; every byte is one parser step.
// A two-entry queue and an output register let the input run while output stalls.
// Reset (i_rst_n low, synchronous) returns to start code search and empties the queue.
`default_nettype none
module dvd_pack_pes_payload_extractor_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dpx_in_if.sink    i_in,
    dpx_out_if.source o_out
);
    logic           w_acc, w_push, w_full, w_empty, w_pop;
    dpx_pkg::t_item w_fitem, w_qitem;

    assign i_in.ready = !w_full;
    assign w_acc      = i_in.valid && !w_full;

    dpx_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_acc(w_acc), .i_byte(i_in.data_byte),
        .o_push(w_push), .o_item(w_fitem)
    );

    dpx_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_push), .i_item(w_fitem),
        .i_pop(w_pop), .o_full(w_full), .o_empty(w_empty), .o_item(w_qitem)
    );

    dpx_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(w_empty), .i_item(w_qitem),
        .o_pop(w_pop), .o_out(o_out)
    );
endmodule
`default_nettype wire

// ----- hw/rtl/dpx_front.sv -----
// Front end: start code search, pack framing and PES header parsing.
// Depends on dpx_pkg.
`default_nettype none
module dpx_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_acc,
    input  wire logic [7:0]      i_byte,
    output logic                 o_push,
    output dpx_pkg::t_item       o_item
);
    localparam logic [2:0] PH_SEEK0  = 3'd0;
    localparam logic [2:0] PH_SEEK1  = 3'd1;
    localparam logic [2:0] PH_SEEK01 = 3'd2;
    localparam logic [2:0] PH_SEEKBA = 3'd3;
    localparam logic [2:0] PH_INPACK = 3'd4;

    localparam logic [2:0] ST_PACK  = 3'd0;
    localparam logic [2:0] ST_SYS   = 3'd1;
    localparam logic [2:0] ST_PES   = 3'd2;
    localparam logic [2:0] ST_SUB   = 3'd3;
    localparam logic [2:0] ST_DATA  = 3'd4;

    localparam int          PW     = dpx_pkg::POS_W;
    localparam logic [PW-1:0] HDR  = PW'(dpx_pkg::PACK_HDR_BYTES);
    localparam logic [PW-1:0] PLEN = PW'(dpx_pkg::PACK_BYTES);
    localparam logic [dpx_pkg::PP_W-1:0] PP_LAST = dpx_pkg::PP_W'(dpx_pkg::PACK_BYTES - 1);

    logic [2:0]               r_ph, n_ph, r_st, n_st;
    logic [dpx_pkg::PP_W-1:0] r_pp, n_pp;
    logic [PW-1:0]            r_ps, n_ps, r_he, n_he, r_pe, n_pe, r_nhs, n_nhs;
    logic [15:0]              r_lc, n_lc;
    logic [7:0]               r_pid, n_pid, r_sid, n_sid;
    logic                     r_fp, n_fp, r_ch, n_ch, r_wo, n_wo;

    // one step of the parse per accepted byte
    always_comb begin
        logic [PW-1:0] p, rel, he, pe;
        logic [7:0]    s;
        logic          emit, last;
        logic [2:0]    strip;
        n_ph = r_ph; n_st = r_st; n_pp = r_pp; n_ps = r_ps; n_he = r_he; n_pe = r_pe;
        n_nhs = r_nhs; n_lc = r_lc; n_pid = r_pid; n_sid = r_sid; n_fp = r_fp;
        n_ch = r_ch; n_wo = r_wo;
        p = PW'(r_pp);
        rel = '0; he = '0; pe = '0; s = '0; strip = '0;
        emit = 1'b0; last = 1'b0;
        o_push = 1'b0;
        if (i_acc) begin
            case (r_ph)
                PH_SEEK0:  if (i_byte == 8'h00) n_ph = PH_SEEK1;
                PH_SEEK1:  n_ph = (i_byte == 8'h00) ? PH_SEEK01 : PH_SEEK0;
                PH_SEEK01: begin
                    if (i_byte == 8'h01) n_ph = PH_SEEKBA;
                    else if (i_byte != 8'h00) n_ph = PH_SEEK0;
                end
                PH_SEEKBA: begin
                    if (i_byte == 8'hba) begin
                        n_ph = PH_INPACK;
                        n_pp = dpx_pkg::PP_W'(4);
                        n_ps = HDR; n_he = '0; n_pe = '0; n_nhs = '0; n_lc = '0;
                        n_pid = '0; n_sid = '0; n_fp = 1'b1; n_st = ST_PACK;
                        n_ch = 1'b0; n_wo = 1'b0;
                    end else begin
                        n_ph = (i_byte == 8'h00) ? PH_SEEK1 : PH_SEEK0;
                    end
                end
                PH_INPACK: begin
                    // pack and system header
                    if (n_st == ST_PACK && p == HDR + PW'(3)) begin
                        if (i_byte == 8'hbb) n_st = ST_SYS;
                        else begin
                            n_ps = HDR;
                            n_st = ST_PES;
                        end
                    end else if (n_st == ST_SYS) begin
                        if (p == HDR + PW'(4)) n_lc = {i_byte, 8'h00};
                        else if (p == HDR + PW'(5)) begin
                            n_lc = {n_lc[15:8], i_byte};
                            n_ps = HDR + PW'(6) + PW'(n_lc);
                            n_st = ST_PES;
                        end
                    end
                    // first PES header
                    if (n_st == ST_PES && p >= n_ps) begin
                        rel = p - n_ps;
                        if (rel == PW'(3)) n_pid = i_byte;
                        else if (rel == PW'(4)) n_lc = {i_byte, 8'h00};
                        else if (rel == PW'(5)) n_lc = {n_lc[15:8], i_byte};
                        else if (rel == PW'(8)) begin
                            n_he = n_ps + PW'(9) + PW'(i_byte);
                            n_pe = n_ps + PW'(6) + PW'(n_lc);
                            n_st = ST_SUB;
                        end
                    end else if (n_st == ST_SUB && p == n_he) begin
                        if (n_pid == 8'hbd) begin
                            s = i_byte & 8'hf8;
                            n_sid = s;
                            if (s inside {[8'h20:8'h38]}) strip = 3'd1;
                            else if (s inside {8'h80, 8'h88, 8'h90}) strip = 3'd4;
                        end
                        n_he = n_he + PW'(strip);
                        n_wo = 1'b1;
                        n_st = ST_DATA;
                        if ((n_pid & 8'he8) == 8'hc0 && n_pe >= n_he) begin
                            n_ch = 1'b1;
                            n_nhs = n_pe;
                        end
                    end
                    // following audio PES headers
                    if (n_ch && p >= n_nhs) begin
                        rel = p - n_nhs;
                        if (rel == '0) begin
                            if (n_nhs + PW'(9) >= PLEN) n_ch = 1'b0;
                        end else if (rel == PW'(3)) begin
                            if ((i_byte & 8'he8) != 8'hc0) n_ch = 1'b0;
                        end else if (rel == PW'(4)) n_lc = {i_byte, 8'h00};
                        else if (rel == PW'(5)) n_lc = {n_lc[15:8], i_byte};
                        else if (rel == PW'(8)) begin
                            he = n_nhs + PW'(9) + PW'(i_byte);
                            pe = n_nhs + PW'(6) + PW'(n_lc);
                            n_he = he;
                            n_pe = pe;
                            if (pe >= he) n_nhs = pe;
                            else n_ch = 1'b0;
                        end
                    end
                    emit = n_wo && p >= n_he && p < n_pe;
                    last = (r_pp == PP_LAST);
                    if (last) n_ph = PH_SEEK0;
                    else n_pp = r_pp + 1'b1;
                    o_push = emit || last;
                    if (o_push) n_fp = 1'b0;
                end
                default: n_ph = PH_SEEK0;
            endcase
        end
        o_item.payload_byte    = emit ? i_byte : 8'h00;
        o_item.byte_valid      = emit;
        o_item.stream_id       = n_pid;
        o_item.substream_id    = n_sid;
        o_item.first_of_packet = r_fp;
        o_item.end_of_packet   = last;
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_SEEK0; r_st <= ST_PACK; r_pp <= '0; r_ps <= HDR;
            r_he <= '0; r_pe <= '0; r_nhs <= '0; r_lc <= '0; r_pid <= '0; r_sid <= '0;
            r_fp <= 1'b0; r_ch <= 1'b0; r_wo <= 1'b0;
        end else begin
            r_ph <= n_ph; r_st <= n_st; r_pp <= n_pp; r_ps <= n_ps;
            r_he <= n_he; r_pe <= n_pe; r_nhs <= n_nhs; r_lc <= n_lc; r_pid <= n_pid;
            r_sid <= n_sid; r_fp <= n_fp; r_ch <= n_ch; r_wo <= n_wo;
        end
    end

    a_last_leaves_pack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && r_ph == PH_INPACK && r_pp == PP_LAST) |=> (r_ph == PH_SEEK0))
        else $error("pack end did not restart search");
    a_push_in_pack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (i_acc && r_ph == PH_INPACK))
        else $error("result outside a pack");
    a_ba_starts_pack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && r_ph == PH_SEEKBA && i_byte == 8'hba) |=> (r_ph == PH_INPACK && r_fp))
        else $error("start code did not open a pack");
endmodule
`default_nettype wire

// ----- hw/rtl/dpx_queue.sv -----
// Two-entry queue of result beats between front end and output stage.
// Depends on dpx_pkg.
`default_nettype none
module dpx_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire dpx_pkg::t_item i_item,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_empty,
    output dpx_pkg::t_item      o_item
);
    dpx_pkg::t_item r_mem [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_item  = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("pop from empty queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("queue count out of range");
endmodule
`default_nettype wire

// ----- hw/rtl/dpx_back.sv -----
// Output stage: registers result beats from the queue onto the output channel.
// Depends on dpx_pkg and dpx_out_if.
`default_nettype none
module dpx_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_empty,
    input  wire dpx_pkg::t_item i_item,
    output logic                o_pop,
    dpx_out_if.source           o_out
);
    logic           r_vld;
    dpx_pkg::t_item r_item;

    assign o_pop = !i_empty && (!r_vld || o_out.ready);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= 1'b0;
        else if (!r_vld || o_out.ready) r_vld <= !i_empty;
    end
    always_ff @(posedge i_clk) begin
        if (o_pop) r_item <= i_item;
    end

    assign o_out.valid           = r_vld;
    assign o_out.payload_byte    = r_item.payload_byte;
    assign o_out.byte_valid      = r_item.byte_valid;
    assign o_out.stream_id       = r_item.stream_id;
    assign o_out.substream_id    = r_item.substream_id;
    assign o_out.first_of_packet = r_item.first_of_packet;
    assign o_out.end_of_packet   = r_item.end_of_packet;
endmodule
`default_nettype wire
